// File: sv/bls_pkg.sv
`default_nettype none

package bls_pkg;

   // func codes of a request transaction
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// File: sv/bls_front.sv
`default_nettype none

module bls_front #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                      req_valid,
   input  wire logic                      req_func,
   input  wire logic [COORD_BITS-1:0]     req_start_x,
   input  wire logic [COORD_BITS-1:0]     req_start_y,
   input  wire logic [COORD_BITS-1:0]     req_end_x,
   input  wire logic [COORD_BITS-1:0]     req_end_y,
   input  bls_pkg::queue_status_type      q_status,
   output logic                           req_stall,
   output logic                           q_push,
   output logic [5*COORD_BITS+2:0]        q_data
);

   typedef struct packed {
      logic                  is_step;
      logic                  steep;
      logic [COORD_BITS-1:0] major_pos;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS-1:0] minor_pos;
      logic [COORD_BITS-1:0] delta_major;
      logic [COORD_BITS-1:0] delta_minor;
      logic                  step_down;
   } entry_type;

   logic [COORD_BITS-1:0] adx, ady;
   logic                  steep;
   logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
   logic [COORD_BITS-1:0] lo_maj, lo_min, hi_maj, hi_min;
   entry_type             entry;

   // steepness: compare the two extents
   always_comb begin
      adx   = (req_start_x > req_end_x) ? req_start_x - req_end_x : req_end_x - req_start_x;
      ady   = (req_start_y > req_end_y) ? req_start_y - req_end_y : req_end_y - req_start_y;
      steep = ady > adx;
      a_maj = steep ? req_start_y : req_start_x;
      a_min = steep ? req_start_x : req_start_y;
      b_maj = steep ? req_end_y   : req_end_x;
      b_min = steep ? req_end_x   : req_end_y;
   end

   // order endpoints so the major coordinate rises
   always_comb begin
      if (a_maj > b_maj) begin
         lo_maj = b_maj;
         lo_min = b_min;
         hi_maj = a_maj;
         hi_min = a_min;
      end else begin
         lo_maj = a_maj;
         lo_min = a_min;
         hi_maj = b_maj;
         hi_min = b_min;
      end
   end

   // classify and build the queue entry
   always_comb begin
      entry.is_step     = (req_func == bls_pkg::FUNC_STEP);
      entry.steep       = steep;
      entry.major_pos   = lo_maj;
      entry.major_end   = hi_maj;
      entry.minor_pos   = lo_min;
      entry.delta_major = hi_maj - lo_maj;
      entry.delta_minor = (lo_min > hi_min) ? lo_min - hi_min : hi_min - lo_min;
      entry.step_down   = !(lo_min < hi_min);
   end

   assign q_data    = entry;
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

endmodule

`default_nettype wire

// File: sv/bls_queue.sv
`default_nettype none

module bls_queue #(
   parameter int WIDTH = 58
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [WIDTH-1:0]     push_data,
   input  wire logic                 pop,
   output logic [WIDTH-1:0]          pop_data,
   output bls_pkg::queue_status_type status
);

   logic [WIDTH-1:0]               slot_ff [bls_pkg::QUEUE_DEPTH];
   logic [bls_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bls_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bls_pkg::QCNT_BITS-1:0]  count_ff, count_in;
   logic                           do_push, do_pop;

   assign status.full  = (count_ff == bls_pkg::QCNT_BITS'(bls_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/bls_back.sv
`default_nettype none

module bls_back #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [5*COORD_BITS+2:0]   q_data,
   input  bls_pkg::queue_status_type      q_status,
   output logic                           q_pop,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output logic [COORD_BITS-1:0]          rsp_pixel_x,
   output logic [COORD_BITS-1:0]          rsp_pixel_y,
   output logic                           rsp_last
);

   localparam int ERR_BITS = COORD_BITS + 2;

   typedef struct packed {
      logic                  is_step;
      logic                  steep;
      logic [COORD_BITS-1:0] major_pos;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS-1:0] minor_pos;
      logic [COORD_BITS-1:0] delta_major;
      logic [COORD_BITS-1:0] delta_minor;
      logic                  step_down;
   } entry_type;

   entry_type                    cmd;
   logic                         active_ff, active_in;
   logic                         steep_ff, steep_in;
   logic [COORD_BITS-1:0]        major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]        major_end_ff, major_end_in;
   logic [COORD_BITS-1:0]        minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]        dmaj_ff, dmaj_in;
   logic [COORD_BITS-1:0]        dmin_ff, dmin_in;
   logic                         down_ff, down_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]        px_ff, px_in;
   logic [COORD_BITS-1:0]        py_ff, py_in;
   logic                         last_ff, last_in;

   logic signed [ERR_BITS-1:0]   err_sum;
   logic signed [ERR_BITS:0]     err_dbl;
   logic signed [ERR_BITS:0]     dmaj_ext;
   logic [COORD_BITS-1:0]        major_next;
   logic                         fin;
   logic                         take_minor;

   assign cmd   = q_data;
   assign q_pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   // error term and step decisions for the current pixel
   always_comb begin
      err_sum    = err_ff + $signed({2'b00, dmin_ff});
      err_dbl    = {err_sum, 1'b0};
      dmaj_ext   = $signed({3'b000, dmaj_ff});
      take_minor = (err_dbl >= dmaj_ext);
      major_next = major_pos_ff + 1'b1;
      fin        = (major_next == major_end_ff);
   end

   // execute the command at the queue head
   always_comb begin
      active_in    = active_ff;
      steep_in     = steep_ff;
      major_pos_in = major_pos_ff;
      major_end_in = major_end_ff;
      minor_pos_in = minor_pos_ff;
      dmaj_in      = dmaj_ff;
      dmin_in      = dmin_ff;
      down_in      = down_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      if (q_pop) begin
         if (!cmd.is_step) begin
            // new line replaces whatever was running
            active_in    = (cmd.delta_major != '0);
            steep_in     = cmd.steep;
            major_pos_in = cmd.major_pos;
            major_end_in = cmd.major_end;
            minor_pos_in = cmd.minor_pos;
            dmaj_in      = cmd.delta_major;
            dmin_in      = cmd.delta_minor;
            down_in      = cmd.step_down;
            err_in       = '0;
         end else if (active_ff) begin
            rsp_valid_in = 1'b1;
            px_in        = steep_ff ? minor_pos_ff : major_pos_ff;
            py_in        = steep_ff ? major_pos_ff : minor_pos_ff;
            last_in      = fin;
            if (take_minor) begin
               minor_pos_in = down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
               err_in       = err_sum - $signed({2'b00, dmaj_ff});
            end else begin
               err_in = err_sum;
            end
            major_pos_in = major_next;
            if (fin) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // line state and output payload
   always_ff @(posedge clock) begin
      steep_ff     <= steep_in;
      major_pos_ff <= major_pos_in;
      major_end_ff <= major_end_in;
      minor_pos_ff <= minor_pos_in;
      dmaj_ff      <= dmaj_in;
      dmin_ff      <= dmin_in;
      down_ff      <= down_in;
      err_ff       <= err_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      last_ff      <= last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = px_ff;
   assign rsp_pixel_y = py_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

// File: sv/bresenham_line_stepper_top.sv
// Bresenham line stepper.
// Request channel (req_valid / req_stall): req_func = load takes two endpoints
// and sets up a new line, producing no response; req_func = step produces the
// next pixel of the active line, or nothing when no line is active.
// Response channel (rsp_valid / rsp_stall): one pixel per step transaction,
// rsp_last marks the final pixel; the far endpoint is not drawn.
// A transaction is taken on a rising edge with valid high and stall low.
// The front classifies and sets up requests combinationally into a
// 4-entry command queue; the back pops one command per cycle unless a
// stalled pixel is pending, and updates the error term with one add, one
// compare and a conditional subtract. Each step's pixel is registered in
// the back's response register, which drives rsp_valid.
// Throughput: one transaction per cycle on both channels while no stall
// holds the flow, set by the back's step loop.
// When rsp_stall is high with a pixel pending, the response register holds
// it, the back stops popping and the queue absorbs up to 4 requests before
// req_stall rises. Synchronous reset empties the queue, drops any active
// line and clears rsp_valid.
`default_nettype none

module bresenham_line_stepper_top #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic [COORD_BITS-1:0] req_start_x,
   input  wire logic [COORD_BITS-1:0] req_start_y,
   input  wire logic [COORD_BITS-1:0] req_end_x,
   input  wire logic [COORD_BITS-1:0] req_end_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_pixel_x,
   output logic [COORD_BITS-1:0]      rsp_pixel_y,
   output logic                       rsp_last
);

   localparam int ENTRY_BITS = 5 * COORD_BITS + 3;

   logic                      q_push;
   logic                      q_pop;
   logic [ENTRY_BITS-1:0]     q_wdata;
   logic [ENTRY_BITS-1:0]     q_rdata;
   bls_pkg::queue_status_type q_status;

   bls_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_func    (req_func),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .q_status    (q_status),
      .req_stall   (req_stall),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   bls_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   bls_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_data      (q_rdata),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// File: sv/bls_checker.sv
`default_nettype none

module bls_checker #(
   parameter int COORD_BITS = 11
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [COORD_BITS-1:0] rsp_pixel_x,
   input wire logic [COORD_BITS-1:0] rsp_pixel_y,
   input wire logic                  rsp_last
);

   // reset drains everything: no response pending afterwards
   a_reset_no_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // reset empties the command queue, so requests are taken at once
   a_reset_no_stall : assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

   // a response is only raised by a back cycle taken with reset released
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!reset))
      else $error("response rose straight out of reset");

   // a stalled response holds its pixel
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind bresenham_line_stepper_top bls_checker #(
   .COORD_BITS (COORD_BITS)
) u_bls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y),
   .rsp_last    (rsp_last)
);

`default_nettype wire

// File: tb/bresenham_line_stepper_top_tb.sv
`timescale 1ns / 100ps

module bresenham_line_stepper_top_tb;

   localparam int COORD_BITS    = 11;
   localparam int MAX_COORD     = (1 << COORD_BITS) - 1;
   localparam int ITEM_TARGET   = 1950;
   localparam int QUIET_ITEMS   = 150;
   localparam int HOLD_CYCLES   = 100;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 400000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      func;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_item_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   // line walker state, one copy of what the block holds
   typedef struct packed {
      logic        active;
      logic        steep;
      logic        step_down;
      coord_type   major_pos;
      coord_type   major_end;
      coord_type   minor_pos;
      coord_type   delta_major;
      coord_type   delta_minor;
      logic [12:0] err;
   } line_state_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_NONE,
      CHK_PIXEL
   } chk_type;

   typedef struct packed {
      logic      func;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      chk_type   chk;
      coord_type px;
      coord_type py;
      logic      plast;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   // directed sequence: idle steps, zero length, short flat line, diagonal
   // across the full range, load over an active line, steep lines at the edges
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_LOAD, 11'd0, 11'd0, 11'd0, 11'd0, CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_LOAD, 11'd0, 11'd0, 11'd3, 11'd0, CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PIXEL, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
        CHK_PIXEL, 11'd1, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PIXEL, 11'd2, 11'd0, 1'b1},
      '{bls_pkg::FUNC_STEP, 11'd2047, 11'd2047, 11'd2047, 11'd2047,
        CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_LOAD, 11'd2047, 11'd2047, 11'd0, 11'd0,
        CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PIXEL, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PIXEL, 11'd1, 11'd1, 1'b0},
      '{bls_pkg::FUNC_LOAD, 11'd2047, 11'd0, 11'd2046, 11'd2047,
        CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0,
        CHK_PIXEL, 11'd2047, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd1365, 11'd682, 11'd1365, 11'd682,
        CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_LOAD, 11'd5, 11'd2040, 11'd7, 11'd2047,
        CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_PREDICT, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0,
        CHK_PIXEL, 11'd7, 11'd2046, 1'b1},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0, CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_LOAD, 11'd100, 11'd50, 11'd40, 11'd20,
        CHK_NONE, 11'd0, 11'd0, 1'b0},
      '{bls_pkg::FUNC_STEP, 11'd0, 11'd0, 11'd0, 11'd0,
        CHK_PIXEL, 11'd40, 11'd20, 1'b0}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_func = bls_pkg::FUNC_LOAD;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_last;

   line_state_type cur = '0;
   pixel_type      pixel_q [$];
   int             errors = 0;
   int             work_items = 0;
   int unsigned    cycle_count = 0;
   bit             gaps_on = 1'b1;
   bit             hold_request = 1'b0;

   bresenham_line_stepper_top #(.COORD_BITS(COORD_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Bresenham walk: a load sets up the line, a step on an active line
   // yields the current pixel and advances the error term
   task automatic advance_line(input req_item_type it, output bit emitted,
                               output pixel_type pix);
      coord_type a_maj, a_min, b_maj, b_min, tmp, nxt;
      bit        steep;
      emitted = 1'b0;
      pix = '0;
      if (it.func == bls_pkg::FUNC_LOAD) begin
         steep = ((it.start_y > it.end_y) ? it.start_y - it.end_y : it.end_y - it.start_y) >
                 ((it.start_x > it.end_x) ? it.start_x - it.end_x : it.end_x - it.start_x);
         a_maj = steep ? it.start_y : it.start_x;
         a_min = steep ? it.start_x : it.start_y;
         b_maj = steep ? it.end_y : it.end_x;
         b_min = steep ? it.end_x : it.end_y;
         // order endpoints so the major coordinate rises
         if (a_maj > b_maj) begin
            tmp = a_maj; a_maj = b_maj; b_maj = tmp;
            tmp = a_min; a_min = b_min; b_min = tmp;
         end
         cur.steep       = steep;
         cur.major_pos   = a_maj;
         cur.major_end   = b_maj;
         cur.minor_pos   = a_min;
         cur.delta_major = b_maj - a_maj;
         cur.delta_minor = (a_min > b_min) ? a_min - b_min : b_min - a_min;
         cur.step_down   = !(a_min < b_min);
         cur.err         = '0;
         cur.active      = (a_maj < b_maj);
      end else if (cur.active) begin
         emitted  = 1'b1;
         pix.x    = cur.steep ? cur.minor_pos : cur.major_pos;
         pix.y    = cur.steep ? cur.major_pos : cur.minor_pos;
         nxt      = cur.major_pos + 1'b1;
         pix.last = (nxt == cur.major_end);
         cur.err  = cur.err + 13'(cur.delta_minor);
         if (2 * int'($signed(cur.err)) >= int'(cur.delta_major)) begin
            cur.minor_pos = cur.step_down ? cur.minor_pos - 1'b1 : cur.minor_pos + 1'b1;
            cur.err       = cur.err - 13'(cur.delta_major);
         end
         cur.major_pos = nxt;
         if (pix.last)
            cur.active = 1'b0;
      end
   endtask

   function automatic req_item_type random_req(input logic func);
      req_item_type it;
      it.func    = func;
      it.start_x = coord_type'($urandom_range(0, MAX_COORD));
      it.start_y = coord_type'($urandom_range(0, MAX_COORD));
      it.end_x   = coord_type'($urandom_range(0, MAX_COORD));
      it.end_y   = coord_type'($urandom_range(0, MAX_COORD));
      return it;
   endfunction

   // endpoint within span of base, folded back inside the coordinate range
   function automatic coord_type offset_coord(input coord_type base, input int span);
      int d;
      d = $urandom_range(0, span);
      if ($urandom_range(0, 1) == 0 && int'(base) >= d)
         return base - coord_type'(d);
      if (int'(base) + d <= MAX_COORD)
         return base + coord_type'(d);
      return base - coord_type'(d);
   endfunction

   // offer one transaction, then record what it should produce
   task automatic send_req(input req_item_type it, input chk_type chk,
                           input pixel_type typed);
      bit        emitted;
      pixel_type pix;
      req_valid   <= 1'b1;
      req_func    <= it.func;
      req_start_x <= it.start_x;
      req_start_y <= it.start_y;
      req_end_x   <= it.end_x;
      req_end_y   <= it.end_y;
      do @(posedge clock); while (req_stall !== 1'b0);
      work_items++;
      advance_line(it, emitted, pix);
      case (chk)
         CHK_PREDICT: begin
            if (emitted)
               pixel_q.push_back(pix);
         end
         CHK_PIXEL: begin
            pixel_q.push_back(typed);
         end
         default: ;
      endcase
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // response side: random stall bursts, plus one long hold on request
   initial begin
      int burst;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int c = 0; c < HOLD_CYCLES; c++)
               @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each response transaction with the oldest expected pixel
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                     rsp_pixel_x, rsp_pixel_y, rsp_last);
            errors++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_pixel_x !== want.x) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, rsp_pixel_x);
               errors++;
            end
            if (rsp_pixel_y !== want.y) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, rsp_pixel_y);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // request side: directed table, then random lines
   initial begin
      req_item_type it;
      pixel_type    typed;
      pixel_type    no_pixel;
      int           pick;
      int           span;
      int           n_steps;
      bit           pressure_done;
      no_pixel = '0;
      pressure_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         it.func    = dir_rows[i].func;
         it.start_x = dir_rows[i].sx;
         it.start_y = dir_rows[i].sy;
         it.end_x   = dir_rows[i].ex;
         it.end_y   = dir_rows[i].ey;
         typed.x    = dir_rows[i].px;
         typed.y    = dir_rows[i].py;
         typed.last = dir_rows[i].plast;
         send_req(it, dir_rows[i].chk, typed);
      end

      while (work_items < ITEM_TARGET) begin
         gaps_on = (work_items < ITEM_TARGET - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 15);
         if (!pressure_done && work_items >= ITEM_TARGET / 2) begin
            // long flat line streamed back to back while responses are held off
            pressure_done = 1'b1;
            gaps_on = 1'b0;
            hold_request = 1'b1;
            it = random_req(bls_pkg::FUNC_LOAD);
            it.start_x = '0;
            it.end_x = coord_type'(MAX_COORD);
            it.end_y = it.start_y;
            send_req(it, CHK_PREDICT, no_pixel);
            repeat (60) send_req(random_req(bls_pkg::FUNC_STEP), CHK_PREDICT, no_pixel);
         end else if (pick == 0) begin
            // noise: random loads and steps
            repeat ($urandom_range(1, 4))
               send_req(random_req(1'($urandom_range(0, 1))), CHK_PREDICT, no_pixel);
         end else begin
            it = random_req(bls_pkg::FUNC_LOAD);
            if (pick != 1) begin
               span = (pick < 4) ? 100 : 12;
               it.end_x = offset_coord(it.start_x, span);
               it.end_y = offset_coord(it.start_y, span);
            end
            send_req(it, CHK_PREDICT, no_pixel);
            n_steps = cur.active ? int'(cur.delta_major) : 0;
            // long lines and some short ones are cut short by the next load
            if (pick == 1 || $urandom_range(0, 7) == 0)
               n_steps = $urandom_range(0, (n_steps > 40) ? 40 : n_steps);
            else
               n_steps += $urandom_range(0, 2);
            repeat (n_steps) send_req(random_req(bls_pkg::FUNC_STEP), CHK_PREDICT, no_pixel);
         end
      end

      req_valid <= 1'b0;
      gaps_on = 1'b0;
      for (int k = 0; k < DRAIN_LIMIT && pixel_q.size() != 0; k++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pixel_q.size() != 0) begin
         $display("%0t: %0d expected pixels never arrived", $time, pixel_q.size());
         errors++;
      end
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
